>>> rtl/rptw_pkg.sv
package rptw_pkg;

    localparam int ENTRY_W        = 64;
    localparam int IDX_W          = 9;
    localparam int PAGE_SHIFT     = 12;
    localparam int VPN_W          = 45;
    localparam int PPN_W          = 52;
    localparam int CMD_W          = 2;
    localparam int ROOT_W         = 6;
    localparam int FREE_W         = 7;
    localparam int LVL_W          = 3;
    localparam int DIGIT_W        = 4;
    localparam int OP_W           = 4;
    localparam int COND_W         = 4;
    localparam int PC_W           = 5;
    localparam int DEF_NUM_FRAMES = 64;
    localparam int DEF_LEVELS     = 5;

    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MAP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNMAP = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [VPN_W-1:0] virtual_page;
        logic [PPN_W-1:0] physical_page;
    } t_in_word;

    typedef struct packed {
        logic             hit;
        logic [PPN_W-1:0] mapped_page;
        logic             status;
    } t_out_word;

    // datapath actions
    localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
    localparam logic [OP_W-1:0] OP_SWEEP  = 4'd1;
    localparam logic [OP_W-1:0] OP_ACCEPT = 4'd2;
    localparam logic [OP_W-1:0] OP_FRAME  = 4'd3;
    localparam logic [OP_W-1:0] OP_READ   = 4'd4;
    localparam logic [OP_W-1:0] OP_MODE   = 4'd5;
    localparam logic [OP_W-1:0] OP_ZSTART = 4'd6;
    localparam logic [OP_W-1:0] OP_LINK   = 4'd7;
    localparam logic [OP_W-1:0] OP_FAIL   = 4'd8;
    localparam logic [OP_W-1:0] OP_HIT    = 4'd9;
    localparam logic [OP_W-1:0] OP_UNMAP  = 4'd10;
    localparam logic [OP_W-1:0] OP_WLEAF  = 4'd11;
    localparam logic [OP_W-1:0] OP_EMIT   = 4'd12;

    // jump conditions
    localparam logic [COND_W-1:0] C_NEVER       = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS      = 4'd1;
    localparam logic [COND_W-1:0] C_NO_ITEM     = 4'd2;
    localparam logic [COND_W-1:0] C_MOD_BUSY    = 4'd3;
    localparam logic [COND_W-1:0] C_CMD_BAD     = 4'd4;
    localparam logic [COND_W-1:0] C_LEVEL_ZERO  = 4'd5;
    localparam logic [COND_W-1:0] C_ENTRY_VALID = 4'd6;
    localparam logic [COND_W-1:0] C_CMD_MAP     = 4'd7;
    localparam logic [COND_W-1:0] C_NO_FRAME    = 4'd8;
    localparam logic [COND_W-1:0] C_ROW_MORE    = 4'd9;
    localparam logic [COND_W-1:0] C_CLR_MORE    = 4'd10;
    localparam logic [COND_W-1:0] C_CMD_UNMAP   = 4'd11;
    localparam logic [COND_W-1:0] C_OUT_FULL    = 4'd12;

    // program steps
    localparam logic [PC_W-1:0] STEP_CLR    = 5'd0;
    localparam logic [PC_W-1:0] STEP_IDLE   = 5'd1;
    localparam logic [PC_W-1:0] STEP_ROOT   = 5'd2;
    localparam logic [PC_W-1:0] STEP_CHK    = 5'd3;
    localparam logic [PC_W-1:0] STEP_DISP   = 5'd4;
    localparam logic [PC_W-1:0] STEP_RD     = 5'd5;
    localparam logic [PC_W-1:0] STEP_TEST   = 5'd6;
    localparam logic [PC_W-1:0] STEP_MISS   = 5'd7;
    localparam logic [PC_W-1:0] STEP_ABORT  = 5'd8;
    localparam logic [PC_W-1:0] STEP_DESC   = 5'd9;
    localparam logic [PC_W-1:0] STEP_NEXT   = 5'd10;
    localparam logic [PC_W-1:0] STEP_LOOP   = 5'd11;
    localparam logic [PC_W-1:0] STEP_ALLOC  = 5'd12;
    localparam logic [PC_W-1:0] STEP_ZSTART = 5'd13;
    localparam logic [PC_W-1:0] STEP_ZERO   = 5'd14;
    localparam logic [PC_W-1:0] STEP_LINK   = 5'd15;
    localparam logic [PC_W-1:0] STEP_FAIL   = 5'd16;
    localparam logic [PC_W-1:0] STEP_LEAF   = 5'd17;
    localparam logic [PC_W-1:0] STEP_LREAD  = 5'd18;
    localparam logic [PC_W-1:0] STEP_LTEST  = 5'd19;
    localparam logic [PC_W-1:0] STEP_HIT    = 5'd20;
    localparam logic [PC_W-1:0] STEP_UNMAP  = 5'd21;
    localparam logic [PC_W-1:0] STEP_WLEAF  = 5'd22;
    localparam logic [PC_W-1:0] STEP_EMIT   = 5'd23;
    localparam logic [PC_W-1:0] STEP_RET    = 5'd24;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } t_ctrl;

    typedef struct packed {
        logic no_item;
        logic mod_busy;
        logic cmd_bad;
        logic cmd_map;
        logic cmd_unmap;
        logic entry_valid;
        logic level_zero;
        logic no_frame;
        logic row_more;
        logic clr_more;
        logic out_full;
    } t_flags;

    function automatic t_ctrl cw(input logic [OP_W-1:0] op, input logic [COND_W-1:0] cond,
                                 input logic [PC_W-1:0] target);
        t_ctrl c;
        c.op     = op;
        c.cond   = cond;
        c.target = target;
        return c;
    endfunction

    // control store
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl c;
        case (pc)
            STEP_CLR:    c = cw(OP_SWEEP,  C_CLR_MORE,    STEP_CLR);
            STEP_IDLE:   c = cw(OP_ACCEPT, C_NO_ITEM,     STEP_IDLE);
            STEP_ROOT:   c = cw(OP_FRAME,  C_MOD_BUSY,    STEP_ROOT);
            STEP_CHK:    c = cw(OP_NOP,    C_CMD_BAD,     STEP_EMIT);
            STEP_DISP:   c = cw(OP_NOP,    C_LEVEL_ZERO,  STEP_LEAF);
            STEP_RD:     c = cw(OP_READ,   C_NEVER,       STEP_CLR);
            STEP_TEST:   c = cw(OP_NOP,    C_ENTRY_VALID, STEP_DESC);
            STEP_MISS:   c = cw(OP_NOP,    C_CMD_MAP,     STEP_ALLOC);
            STEP_ABORT:  c = cw(OP_NOP,    C_ALWAYS,      STEP_EMIT);
            STEP_DESC:   c = cw(OP_MODE,   C_NEVER,       STEP_CLR);
            STEP_NEXT:   c = cw(OP_FRAME,  C_MOD_BUSY,    STEP_NEXT);
            STEP_LOOP:   c = cw(OP_NOP,    C_ALWAYS,      STEP_DISP);
            STEP_ALLOC:  c = cw(OP_NOP,    C_NO_FRAME,    STEP_FAIL);
            STEP_ZSTART: c = cw(OP_ZSTART, C_NEVER,       STEP_CLR);
            STEP_ZERO:   c = cw(OP_SWEEP,  C_ROW_MORE,    STEP_ZERO);
            STEP_LINK:   c = cw(OP_LINK,   C_ALWAYS,      STEP_DISP);
            STEP_FAIL:   c = cw(OP_FAIL,   C_ALWAYS,      STEP_EMIT);
            STEP_LEAF:   c = cw(OP_NOP,    C_CMD_MAP,     STEP_WLEAF);
            STEP_LREAD:  c = cw(OP_READ,   C_NEVER,       STEP_CLR);
            STEP_LTEST:  c = cw(OP_NOP,    C_CMD_UNMAP,   STEP_UNMAP);
            STEP_HIT:    c = cw(OP_HIT,    C_ALWAYS,      STEP_EMIT);
            STEP_UNMAP:  c = cw(OP_UNMAP,  C_ALWAYS,      STEP_EMIT);
            STEP_WLEAF:  c = cw(OP_WLEAF,  C_ALWAYS,      STEP_EMIT);
            STEP_EMIT:   c = cw(OP_EMIT,   C_OUT_FULL,    STEP_EMIT);
            STEP_RET:    c = cw(OP_NOP,    C_ALWAYS,      STEP_IDLE);
            default:     c = cw(OP_NOP,    C_ALWAYS,      STEP_IDLE);
        endcase
        return c;
    endfunction

endpackage

>>> rtl/rptw_mod.sv
module rptw_mod #(
    parameter int NUM_FRAMES = rptw_pkg::DEF_NUM_FRAMES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rptw_pkg::PPN_W-1:0]    i_value,
    output logic                          o_busy,
    output logic [$clog2(NUM_FRAMES)-1:0] o_result
);
    import rptw_pkg::*;

    localparam int  FB    = $clog2(NUM_FRAMES);
    localparam bit  POW2  = ((1 << FB) == NUM_FRAMES);
    localparam int  NDIG  = (PPN_W + DIGIT_W - 1) / DIGIT_W;
    localparam int  STEPS = POW2 ? 0 : NDIG;
    localparam int  CW    = $clog2(NDIG + 1);

    logic [CW-1:0] r_cnt;

    // when NUM_FRAMES is not a power of two: one digit per cycle, top digit first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_busy = (r_cnt != '0);

    generate
        if (POW2) begin : g_mask
            logic [FB-1:0] r_res;
            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_res <= i_value[FB-1:0];
                end
            end
            assign o_result = r_res;
        end else begin : g_digit
            localparam int XW = FB + DIGIT_W;
            logic [PPN_W-1:0] r_val;
            logic [FB-1:0]    r_rem;
            logic [XW-1:0]    x;

            // x < 16*N, so four restoring subtracts bring it below N
            always_comb begin
                x = {r_rem, r_val[PPN_W-1 -: DIGIT_W]};
                for (int k = DIGIT_W - 1; k >= 0; k--) begin
                    if (x >= (XW'(NUM_FRAMES) << k)) begin
                        x = x - (XW'(NUM_FRAMES) << k);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_val <= i_value;
                    r_rem <= '0;
                end else if (r_cnt != '0) begin
                    r_val <= r_val << DIGIT_W;
                    r_rem <= x[FB-1:0];
                end
            end
            assign o_result = r_rem;
        end
    endgenerate

endmodule

>>> rtl/rptw_datapath.sv
module rptw_datapath #(
    parameter int NUM_FRAMES = rptw_pkg::DEF_NUM_FRAMES,
    parameter int LEVELS     = rptw_pkg::DEF_LEVELS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rptw_pkg::t_ctrl             i_ctrl,
    output rptw_pkg::t_flags            o_flags,
    input  logic [rptw_pkg::ROOT_W-1:0] i_root_frame,
    input  logic [rptw_pkg::FREE_W-1:0] i_first_free_frame,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  rptw_pkg::t_in_word          i_in_word,
    output logic                        o_valid,
    input  logic                        i_ready,
    output rptw_pkg::t_out_word         o_out_word
);
    import rptw_pkg::*;

    localparam int FB    = $clog2(NUM_FRAMES);
    localparam int AW    = FB + IDX_W;
    localparam int DEPTH = NUM_FRAMES * (1 << IDX_W);
    localparam int FUW   = $clog2(NUM_FRAMES + 1);
    localparam int NW    = ((FUW > FREE_W) ? FUW : FREE_W) + 1;
    localparam int VXW   = IDX_W * 6;

    logic [ENTRY_W-1:0] mem [0:DEPTH-1];

    logic [CMD_W-1:0]   r_cmd;
    logic [VPN_W-1:0]   r_vpn;
    logic [PPN_W-1:0]   r_ppn;
    logic [LVL_W-1:0]   r_level;
    logic [FB-1:0]      r_frame;
    logic [FB-1:0]      r_new;
    logic [AW-1:0]      r_addr;
    logic [ENTRY_W-1:0] r_rdata;
    logic [AW-1:0]      r_swp;
    logic [FUW-1:0]     r_used;
    logic               r_hit;
    logic [PPN_W-1:0]   r_page;
    logic               r_status;
    logic               r_out_valid;
    t_out_word          r_out;

    logic [VXW-1:0]     vext;
    logic [IDX_W-1:0]   idx;
    logic [AW-1:0]      rd_addr;
    logic [NW-1:0]      nxt;
    logic               take;
    logic               mod_start;
    logic [PPN_W-1:0]   mod_value;
    logic               mod_busy;
    logic [FB-1:0]      mod_result;
    logic               we;
    logic [AW-1:0]      wa;
    logic [ENTRY_W-1:0] wd;
    logic               re;

    // index bits of the current level
    always_comb begin
        vext = {(VXW - VPN_W)'(0), r_vpn};
        case (r_level)
            3'd0:    idx = vext[0*IDX_W +: IDX_W];
            3'd1:    idx = vext[1*IDX_W +: IDX_W];
            3'd2:    idx = vext[2*IDX_W +: IDX_W];
            3'd3:    idx = vext[3*IDX_W +: IDX_W];
            3'd4:    idx = vext[4*IDX_W +: IDX_W];
            3'd5:    idx = vext[5*IDX_W +: IDX_W];
            default: idx = '0;
        endcase
    end

    assign rd_addr   = {r_frame, idx};
    assign nxt       = NW'(i_first_free_frame) + NW'(r_used);
    assign o_ready   = (i_ctrl.op == OP_ACCEPT);
    assign take      = o_ready && i_valid;
    assign mod_start = take || (i_ctrl.op == OP_MODE);
    assign mod_value = (i_ctrl.op == OP_MODE) ? r_rdata[ENTRY_W-1:PAGE_SHIFT]
                                              : PPN_W'(i_root_frame);
    assign re        = (i_ctrl.op == OP_READ);

    rptw_mod #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mod_start),
        .i_value  (mod_value),
        .o_busy   (mod_busy),
        .o_result (mod_result)
    );

    // single write port
    always_comb begin
        we = 1'b0;
        wa = r_addr;
        wd = '0;
        case (i_ctrl.op)
            OP_SWEEP: begin
                we = 1'b1;
                wa = r_swp;
            end
            OP_LINK: begin
                we = 1'b1;
                wd = (ENTRY_W'(r_new) << PAGE_SHIFT) | ENTRY_W'(1);
            end
            OP_UNMAP: begin
                we = 1'b1;
                wd = r_rdata & ~ENTRY_W'(1);
            end
            OP_WLEAF: begin
                we = 1'b1;
                wa = rd_addr;
                wd = {r_ppn, (PAGE_SHIFT - 1)'(0), 1'b1};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swp       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.op == OP_SWEEP) begin
                r_swp <= r_swp + 1'b1;
            end else if (i_ctrl.op == OP_ZSTART) begin
                r_swp <= {nxt[FB-1:0], IDX_W'(0)};
            end
            if (i_ctrl.op == OP_ZSTART) begin
                r_used <= r_used + 1'b1;
            end
            if (i_ctrl.op == OP_EMIT && !r_out_valid) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd    <= i_in_word.command;
            r_vpn    <= i_in_word.virtual_page;
            r_ppn    <= i_in_word.physical_page;
            r_level  <= LVL_W'(LEVELS - 1);
            r_hit    <= 1'b0;
            r_page   <= '0;
            r_status <= 1'b0;
        end
        case (i_ctrl.op)
            OP_FRAME: r_frame <= mod_result;
            OP_READ:  r_addr  <= rd_addr;
            OP_MODE:  r_level <= r_level - 1'b1;
            OP_ZSTART: r_new  <= nxt[FB-1:0];
            OP_LINK: begin
                r_frame <= r_new;
                r_level <= r_level - 1'b1;
            end
            OP_FAIL:  r_status <= 1'b1;
            OP_HIT: begin
                if (r_rdata[0]) begin
                    r_hit  <= 1'b1;
                    r_page <= r_rdata[ENTRY_W-1:PAGE_SHIFT];
                end
            end
            default: begin
            end
        endcase
        if (i_ctrl.op == OP_EMIT && !r_out_valid) begin
            r_out.hit         <= r_hit;
            r_out.mapped_page <= r_page;
            r_out.status      <= r_status;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_word = r_out;

    always_comb begin
        o_flags.no_item     = !i_valid;
        o_flags.mod_busy    = mod_busy;
        o_flags.cmd_bad     = (r_cmd != CMD_QUERY) && (r_cmd != CMD_MAP) && (r_cmd != CMD_UNMAP);
        o_flags.cmd_map     = (r_cmd == CMD_MAP);
        o_flags.cmd_unmap   = (r_cmd == CMD_UNMAP);
        o_flags.entry_valid = r_rdata[0];
        o_flags.level_zero  = (r_level == '0);
        o_flags.no_frame    = (nxt >= NW'(NUM_FRAMES));
        o_flags.row_more    = (r_swp[IDX_W-1:0] != {IDX_W{1'b1}});
        o_flags.clr_more    = (r_swp != AW'(DEPTH - 1));
        o_flags.out_full    = r_out_valid;
    end

endmodule

>>> rtl/rptw_seq.sv
module rptw_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rptw_pkg::t_flags i_flags,
    output rptw_pkg::t_ctrl  o_ctrl
);
    import rptw_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           ctrl;
    logic            jump;

    assign ctrl = ucode(r_pc);

    always_comb begin
        case (ctrl.cond)
            C_NEVER:       jump = 1'b0;
            C_ALWAYS:      jump = 1'b1;
            C_NO_ITEM:     jump = i_flags.no_item;
            C_MOD_BUSY:    jump = i_flags.mod_busy;
            C_CMD_BAD:     jump = i_flags.cmd_bad;
            C_LEVEL_ZERO:  jump = i_flags.level_zero;
            C_ENTRY_VALID: jump = i_flags.entry_valid;
            C_CMD_MAP:     jump = i_flags.cmd_map;
            C_NO_FRAME:    jump = i_flags.no_frame;
            C_ROW_MORE:    jump = i_flags.row_more;
            C_CLR_MORE:    jump = i_flags.clr_more;
            C_CMD_UNMAP:   jump = i_flags.cmd_unmap;
            C_OUT_FULL:    jump = i_flags.out_full;
            default:       jump = 1'b0;
        endcase
        n_pc = jump ? ctrl.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_CLR;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = ctrl;

endmodule

>>> rtl/radix_page_table_walker.sv
// With every level present a query or unmap walk runs longest; a miss ends it sooner.
//   Each table a map allocates adds a pass that zeroes one 512-entry frame one entry a cycle,
//   and each frame reduction adds a digit-by-digit pass when NUM_FRAMES is not a power of two.
// Throughput: one word at a time; the next is taken at the idle step after the return step,
//   even while the output word still waits for ready.
// Reset: sync, active low; the store clear then runs with ready low.
module radix_page_table_walker #(
    parameter int NUM_FRAMES = rptw_pkg::DEF_NUM_FRAMES,
    parameter int LEVELS     = rptw_pkg::DEF_LEVELS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_ready,
    input  rptw_pkg::t_in_word  i_in_word,
    output logic                o_valid,
    input  logic                i_ready,
    output rptw_pkg::t_out_word o_out_word
);
    import rptw_pkg::*;

    // register select is the word address bit
    localparam logic REG_ROOT = 1'b0;
    localparam logic REG_FREE = 1'b1;

    logic [ROOT_W-1:0] r_root_frame;
    logic [FREE_W-1:0] r_first_free_frame;
    t_ctrl             w_ctrl;
    t_flags            w_flags;

    // Configuration: zero wait states, write on the access phase.
    // Configuration writes are taken throughout, the store clear included.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_frame       <= '0;
            r_first_free_frame <= FREE_W'(1);
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_ROOT: r_root_frame       <= pwdata[ROOT_W-1:0];
                REG_FREE: r_first_free_frame <= pwdata[FREE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read back the addressed register
    always_comb begin
        case (paddr[2])
            REG_ROOT: prdata = 32'(r_root_frame);
            REG_FREE: prdata = 32'(r_first_free_frame);
            default:  prdata = '0;
        endcase
    end

    // Sequencer: step counter over the control store, one control word per cycle.
    rptw_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    // Datapath: frame store, walk registers, allocator, frame reducer and the output word register.
    rptw_datapath #(
        .NUM_FRAMES (NUM_FRAMES),
        .LEVELS     (LEVELS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctrl             (w_ctrl),
        .o_flags            (w_flags),
        .i_root_frame       (r_root_frame),
        .i_first_free_frame (r_first_free_frame),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_in_word          (i_in_word),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_out_word         (o_out_word)
    );

`ifndef NO_ASSERTIONS
    // one word in flight: accepting drops ready until the walk finishes
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second word accepted during a walk");

    // the store clear follows reset, so no word is taken right away
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("word accepted before the store clear");

    // the frame reducer is idle whenever the sequencer waits for a word
    a_mod_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_ACCEPT) |-> !w_flags.mod_busy)
        else $error("frame reducer busy while waiting for a word");
`endif

endmodule

>>> sim/rptw_result_checker.sv
module rptw_result_checker #(
    parameter logic [2:0] ROOT_FRAME_ADDR = 3'd0,
    parameter logic [2:0] FIRST_FREE_ADDR = 3'd4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    input  logic                i_pready,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  rptw_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  rptw_pkg::t_out_word i_out_word,
    output int                  o_fail_count,
    output int                  o_pending
);
    import rptw_pkg::*;

    localparam int FRAMES  = DEF_NUM_FRAMES;
    localparam int DEPTH   = DEF_LEVELS;
    localparam int ENTRIES = 1 << IDX_W;

    // shadow copy of the frame store and allocator
    logic [ENTRY_W-1:0] pt_store [0:FRAMES*ENTRIES-1];
    logic [ROOT_W-1:0]  root_frame_q;
    logic [FREE_W-1:0]  first_free_q;
    int unsigned        frames_taken;

    t_out_word expected_translations[$];
    t_out_word want;
    int        mismatches = 0;
    int unsigned wipe_idx;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int unsigned entry_index(input logic [63:0] frame,
                                                input logic [VPN_W-1:0] vpn,
                                                input int level);
        logic [VPN_W-1:0] shifted;
        shifted = vpn >> (IDX_W * level);
        return int'((frame % FRAMES) * ENTRIES + shifted[IDX_W-1:0]);
    endfunction

    // follow the intermediate levels; report whether a leaf slot was reached
    function automatic logic find_leaf(input logic [VPN_W-1:0] vpn, output int unsigned leaf);
        logic [63:0] frame;
        logic [ENTRY_W-1:0] e;
        int lvl;
        frame = 64'(root_frame_q);
        for (lvl = DEPTH - 1; lvl > 0; lvl--) begin
            e = pt_store[entry_index(frame, vpn, lvl)];
            if (!e[0]) return 1'b0;
            frame = e >> PAGE_SHIFT;
        end
        leaf = entry_index(frame, vpn, 0);
        return 1'b1;
    endfunction

    // build missing levels, then write the leaf; 1 when frames ran out
    function automatic logic install_mapping(input logic [VPN_W-1:0] vpn,
                                             input logic [PPN_W-1:0] ppn);
        logic [63:0] frame;
        logic [63:0] fresh;
        logic [ENTRY_W-1:0] e;
        int unsigned s;
        int lvl;
        int k;
        frame = 64'(root_frame_q);
        for (lvl = DEPTH - 1; lvl > 0; lvl--) begin
            s = entry_index(frame, vpn, lvl);
            e = pt_store[s];
            if (!e[0]) begin
                fresh = 64'(first_free_q) + 64'(frames_taken);
                if (fresh >= FRAMES) return 1'b1;
                frames_taken++;
                for (k = 0; k < ENTRIES; k++) pt_store[fresh * ENTRIES + k] = '0;
                e = (fresh << PAGE_SHIFT) | 64'd1;
                pt_store[s] = e;
            end
            frame = e >> PAGE_SHIFT;
        end
        pt_store[entry_index(frame, vpn, 0)] = (64'(ppn) << PAGE_SHIFT) | 64'd1;
        return 1'b0;
    endfunction

    function automatic t_out_word translate(input t_in_word w);
        t_out_word r;
        int unsigned leaf;
        r = '0;
        case (w.command)
            CMD_QUERY: begin
                if (find_leaf(w.virtual_page, leaf)) begin
                    if (pt_store[leaf][0]) begin
                        r.hit         = 1'b1;
                        r.mapped_page = pt_store[leaf][ENTRY_W-1:PAGE_SHIFT];
                    end
                end
            end
            CMD_MAP: begin
                r.status = install_mapping(w.virtual_page, w.physical_page);
            end
            CMD_UNMAP: begin
                if (find_leaf(w.virtual_page, leaf)) pt_store[leaf][0] = 1'b0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_val,
                                        input logic [63:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected 0x%0h actual 0x%0h", name, exp_val, got_val);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (wipe_idx = 0; wipe_idx < FRAMES * ENTRIES; wipe_idx++) pt_store[wipe_idx] = '0;
            root_frame_q = '0;
            first_free_q = FREE_W'(1);
            frames_taken = 0;
            expected_translations.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == ROOT_FRAME_ADDR) root_frame_q = i_pwdata[ROOT_W-1:0];
                else if (i_paddr == FIRST_FREE_ADDR) first_free_q = i_pwdata[FREE_W-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_translations.size() == 0) begin
                    $error("result word with nothing pending");
                    mismatches++;
                end else begin
                    want = expected_translations.pop_front();
                    check_field("hit", 64'(want.hit), 64'(i_out_word.hit));
                    check_field("mapped_page", 64'(want.mapped_page), 64'(i_out_word.mapped_page));
                    check_field("status", 64'(want.status), 64'(i_out_word.status));
                end
            end
            if (i_in_valid && i_in_ready) expected_translations.push_back(translate(i_in_word));
        end
        o_pending    <= expected_translations.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> sim/tb_radix_page_table_walker.sv
module tb_radix_page_table_walker;
    import rptw_pkg::*;

    // register byte addresses on the config port
    localparam logic [2:0] REG_ROOT_FRAME = 3'd0;
    localparam logic [2:0] REG_FIRST_FREE = 3'd4;

    // command code the block must treat as a no-op
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    // the post-reset clear pass alone moves no word, so the limit must cover it
    localparam int STUCK_LIMIT = 200000;
    localparam int TAIL_CYCLES = 100;
    localparam int LONG_HOLD   = 400;
    localparam int POOL_SIZE   = 16;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_word    i_in_word = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_word   o_out_word;

    int fail_count;
    int pending;

    // asks the receiver for one long hold-off
    logic hold_off_req = 1'b0;

    // virtual pages sharing upper levels, so most maps land in tables that exist
    logic [VPN_W-1:0] vpn_pool [0:POOL_SIZE-1];

    int unsigned stuck_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    radix_page_table_walker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_word  (i_in_word),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_word (o_out_word)
    );

    rptw_result_checker #(
        .ROOT_FRAME_ADDR (REG_ROOT_FRAME),
        .FIRST_FREE_ADDR (REG_FIRST_FREE)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_word   (o_out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver: mix steady, random and periodic stall segments; once asked,
    // hold off for a long stretch so the block backs up into its input.
    initial begin : receiver
        int  seg_len;
        int  pick;
        int  k;
        int  on_len;
        int  off_len;
        bit  hold_off_done;
        hold_off_done = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                pick    = $urandom_range(0, 3);
                seg_len = $urandom_range(16, 120);
                on_len  = $urandom_range(1, 6);
                off_len = $urandom_range(1, 6);
                for (k = 0; k < seg_len; k++) begin
                    if (pick == 0)
                        i_ready <= 1'b1;
                    else if (pick == 3)
                        i_ready <= ((k % (on_len + off_len)) < on_len);
                    else
                        i_ready <= ($urandom_range(0, 3) != 0);
                    @(posedge i_clk);
                end
            end
        end
    end

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input t_in_word w);
        i_in_word <= w;
        i_valid   <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_fields(input logic [CMD_W-1:0] cmd, input logic [VPN_W-1:0] vpn,
                               input logic [PPN_W-1:0] ppn);
        t_in_word w;
        w.command       = cmd;
        w.virtual_page  = vpn;
        w.physical_page = ppn;
        send_word(w);
    endtask

    // Drop valid for a gap set by n, which must be at least 1.
    task automatic idle_sender(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic quiesce();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the write lands at the edge with pready high.
    // Then return the bus to idle.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reprogram the walk root and allocator base once every pending result has come back.
    task automatic set_tables(input logic [ROOT_W-1:0] root, input logic [FREE_W-1:0] first_free);
        quiesce();
        reg_write(REG_ROOT_FRAME, 32'(root));
        reg_write(REG_FIRST_FREE, 32'(first_free));
    endtask

    task automatic refill_pool();
        logic [63:0] r;
        int k;
        r = {$urandom, $urandom};
        vpn_pool[0] = r[VPN_W-1:0];
        for (k = 1; k < POOL_SIZE; k++) begin
            r = {$urandom, $urandom};
            vpn_pool[k] = vpn_pool[0];
            vpn_pool[k][IDX_W-1:0] = r[IDX_W-1:0];
            // now and then branch one level higher too
            if ($urandom_range(0, 3) == 0) vpn_pool[k][2*IDX_W-1:IDX_W] = r[2*IDX_W-1:IDX_W];
        end
    endtask

    // Mostly pooled pages with a query/map heavy mix, plus some fully random noise.
    function automatic t_in_word random_item();
        t_in_word w;
        logic [63:0] r_vpn;
        logic [63:0] r_ppn;
        int pick;
        r_vpn = {$urandom, $urandom};
        r_ppn = {$urandom, $urandom};
        w.physical_page = r_ppn[PPN_W-1:0];
        if ($urandom_range(0, 99) < 10) begin
            w.virtual_page = r_vpn[VPN_W-1:0];
            w.command      = CMD_W'($urandom_range(0, 3));
        end else begin
            w.virtual_page = vpn_pool[$urandom_range(0, POOL_SIZE - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 40)
                w.command = CMD_MAP;
            else if (pick < 80)
                w.command = CMD_QUERY;
            else if (pick < 95)
                w.command = CMD_UNMAP;
            else
                w.command = CMD_RESERVED;
        end
        return w;
    endfunction

    // Reprogram the tables, then send count random words in bursts, mostly with random gaps between them.
    task automatic random_phase(input int count, input logic [ROOT_W-1:0] root,
                                input logic [FREE_W-1:0] first_free, input bit new_pool,
                                input bit long_stall);
        int n;
        int burst_left;
        burst_left = 0;
        set_tables(root, first_free);
        if (new_pool) refill_pool();
        for (n = 0; n < count; n++) begin
            if (long_stall && n == count / 4) hold_off_req <= 1'b1;
            if (burst_left == 0) begin
                if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            send_word(random_item());
        end
    endtask

    initial begin : stimulus
        logic [63:0] r;
        // hold reset, then release it for good
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default tree: root 0, allocator from frame 1 (writes land during the clear pass)
        set_tables(ROOT_W'(0), FREE_W'(1));
        send_fields(CMD_QUERY, '0, '0);                       // empty store
        send_fields(CMD_UNMAP, '0, '0);                       // unmap of nothing
        send_fields(CMD_MAP, '0, {PPN_W{1'b1}});              // builds four levels
        send_fields(CMD_QUERY, '0, '0);
        send_fields(CMD_MAP, {VPN_W{1'b1}}, '0);              // opposite corner of the tree
        send_fields(CMD_QUERY, {VPN_W{1'b1}}, {PPN_W{1'b1}});
        send_fields(CMD_RESERVED, {VPN_W{1'b1}}, {PPN_W{1'b1}});
        send_fields(CMD_UNMAP, '0, '0);
        send_fields(CMD_QUERY, '0, '0);                       // leaf present but invalid
        send_fields(CMD_MAP, '0, 52'h123456789ABCD);          // remap, no allocation
        send_fields(CMD_MAP, VPN_W'(1), 52'hFEDCBA9876543);   // sibling in the same leaf table
        send_fields(CMD_QUERY, VPN_W'(1), '0);
        send_fields(CMD_QUERY, VPN_W'(1) << (4 * IDX_W), '0); // miss at the top level
        send_fields(CMD_UNMAP, {VPN_W{1'b1}}, '0);
        send_fields(CMD_UNMAP, {VPN_W{1'b1}}, '0);            // already cleared
        send_fields(CMD_QUERY, {VPN_W{1'b1}}, '0);

        // root on the old leaf table: page numbers now act as frame numbers, wrapped
        set_tables(ROOT_W'(4), FREE_W'(1));
        send_fields(CMD_QUERY, '0, '0);
        send_fields(CMD_QUERY, VPN_W'(1) << (4 * IDX_W), '0);
        send_fields(CMD_UNMAP, VPN_W'(1) << (4 * IDX_W), '0);

        // root on the next frame to be handed out: the first allocation wipes it
        set_tables(ROOT_W'(9), FREE_W'(1));
        r = {$urandom, $urandom};
        send_fields(CMD_MAP, {9'd1, 9'd2, 9'd3, 9'd4, 9'd5}, r[PPN_W-1:0]);
        send_fields(CMD_QUERY, {9'd1, 9'd2, 9'd3, 9'd4, 9'd5}, '0);
        send_fields(CMD_MAP, {9'd1, 9'd1, 9'd1, 9'd1, 9'd7}, ~r[PPN_W-1:0]);
        send_fields(CMD_QUERY, {9'd1, 9'd1, 9'd1, 9'd1, 9'd7}, '0);

        // allocator base at the end of the store: any new level must fail
        set_tables({ROOT_W{1'b1}}, FREE_W'(DEF_NUM_FRAMES));
        r = {$urandom, $urandom};
        send_fields(CMD_MAP, r[VPN_W-1:0], ~r[PPN_W-1:0]);
        send_fields(CMD_QUERY, r[VPN_W-1:0], '0);

        // random part, walking through several table settings
        random_phase(400, ROOT_W'($urandom_range(0, 63)), FREE_W'($urandom_range(1, 40)),
                     1'b1, 1'b1);
        random_phase(330, {ROOT_W{1'b1}}, FREE_W'(DEF_NUM_FRAMES), 1'b1, 1'b0);
        random_phase(400, ROOT_W'(0), FREE_W'(1), 1'b1, 1'b0);
        random_phase(400, ROOT_W'(0), FREE_W'($urandom_range(1, 64)), 1'b0, 1'b0);

        // drain, then give late or stray words time to show up
        quiesce();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rptw_pkg.sv
rtl/rptw_mod.sv
rtl/rptw_datapath.sv
rtl/rptw_seq.sv
rtl/radix_page_table_walker.sv
sim/rptw_result_checker.sv
sim/tb_radix_page_table_walker.sv
